FILE: rtl/slipd_pkg.sv
// shared types and constants for the slip frame decoder
package slipd_pkg;

    // slip special bytes
    localparam logic [7:0] SLIP_END     = 8'o300;
    localparam logic [7:0] SLIP_ESC     = 8'o333;
    localparam logic [7:0] SLIP_ESC_END = 8'o334;
    localparam logic [7:0] SLIP_ESC_ESC = 8'o335;

    // frame status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_PROTO = 2'd2;
    localparam logic [1:0] ST_CRC   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CRC_ENABLE = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
    localparam logic [1:0] REG_CRC_POLY   = 2'd2;
    localparam logic [1:0] REG_CRC_INIT   = 2'd3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // classified line events
    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_END   = 2'd1,
        OP_PROTO = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    // one result word
    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_byte;
        logic [1:0]  status_code;
        logic [15:0] frame_length;
    } result_t;

    // configuration seen by the back end
    typedef struct packed {
        logic        crc_enable;
        logic [15:0] max_length;
        logic [7:0]  crc_polynomial;
        logic [7:0]  crc_initial;
    } cfg_t;

endpackage

FILE: rtl/slipd_front.sv
// front end: accepts line bytes, undoes escapes and classifies them
module slipd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     rx_byte,
    input  logic           q_full,
    output logic           q_wr,
    output slipd_pkg::op_t q_op
);
    import slipd_pkg::*;

    logic accept;
    logic esc_pending_reg;
    logic esc_pending_next;

    assign accept = push && !q_full;

    // escape decode and classification
    always_comb
    begin
        esc_pending_next = esc_pending_reg;
        q_wr             = 1'b0;
        q_op.kind        = OP_DATA;
        q_op.data        = rx_byte;
        if (accept)
        begin
            if (esc_pending_reg)
            begin
                esc_pending_next = 1'b0;
                q_wr             = 1'b1;
                if (rx_byte == SLIP_ESC_END)
                begin
                    q_op.data = SLIP_END;
                end
                else if (rx_byte == SLIP_ESC_ESC)
                begin
                    q_op.data = SLIP_ESC;
                end
                else
                begin
                    q_op.kind = OP_PROTO;
                end
            end
            else if (rx_byte == SLIP_END)
            begin
                q_wr      = 1'b1;
                q_op.kind = OP_END;
            end
            else if (rx_byte == SLIP_ESC)
            begin
                esc_pending_next = 1'b1;
            end
            else
            begin
                q_wr = 1'b1;
            end
        end
    end

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pending_reg <= 1'b0;
        end
        else
        begin
            esc_pending_reg <= esc_pending_next;
        end
    end

endmodule

FILE: rtl/slipd_fifo.sv
// short queue of classified words between front and back
module slipd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  slipd_pkg::op_t wr_op,
    input  logic           rd,
    output slipd_pkg::op_t rd_op,
    output logic           full,
    output logic           empty
);
    import slipd_pkg::*;

    op_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rd_op = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

FILE: rtl/slipd_back.sv
// back end: frame counting, crc hold-back and check, result register
module slipd_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  slipd_pkg::cfg_t    cfg,
    input  logic               q_empty,
    input  slipd_pkg::op_t     q_op,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output slipd_pkg::result_t result
);
    import slipd_pkg::*;

    localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [7:0]             held_reg;
    logic [7:0]             held_next;
    logic [7:0]             crc_reg;
    logic [7:0]             crc_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_reg;
    result_t                out_next;
    logic                   take;
    logic                   at_limit;
    logic [CMP_W-1:0]       emitted;
    logic [7:0]             crc_upd;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_byte(
        input logic [7:0] crc,
        input logic [7:0] b,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign take   = !q_empty && (!out_valid_reg || pop);
    assign q_rd   = take;

    // frame length limit and emitted count
    assign at_limit = (CMP_W'(count_reg) >= CMP_W'(cfg.max_length)) || (&count_reg);
    assign emitted  = CMP_W'(count_reg)
                    - CMP_W'(cfg.crc_enable && (count_reg != '0));
    assign crc_upd  = crc8_byte(crc_reg, held_reg, cfg.crc_polynomial);

    // frame processing
    always_comb
    begin
        count_next     = count_reg;
        held_next      = held_reg;
        crc_next       = crc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (take)
        begin
            out_next.is_status    = 1'b1;
            out_next.data_byte    = 8'd0;
            out_next.status_code  = ST_OK;
            out_next.frame_length = emitted[15:0];
            unique case (q_op.kind)
                OP_PROTO:
                begin
                    out_next.status_code = ST_PROTO;
                    out_valid_next       = 1'b1;
                    count_next           = '0;
                    crc_next             = cfg.crc_initial;
                end
                OP_END:
                begin
                    if (count_reg != '0)
                    begin
                        if (cfg.crc_enable
                            && ((count_reg == LENGTH_BITS'(1)) || (held_reg != crc_reg)))
                        begin
                            out_next.status_code = ST_CRC;
                        end
                        out_valid_next = 1'b1;
                        count_next     = '0;
                        crc_next       = cfg.crc_initial;
                    end
                end
                OP_DATA:
                begin
                    if (at_limit)
                    begin
                        out_next.status_code = ST_TRUNC;
                        out_valid_next       = 1'b1;
                        count_next           = '0;
                        crc_next             = cfg.crc_initial;
                    end
                    else
                    begin
                        count_next            = count_reg + 1'b1;
                        out_next.is_status    = 1'b0;
                        out_next.frame_length = 16'd0;
                        if (cfg.crc_enable)
                        begin
                            held_next = q_op.data;
                            if (count_reg != '0)
                            begin
                                crc_next           = crc_upd;
                                out_next.data_byte = held_reg;
                                out_valid_next     = 1'b1;
                            end
                        end
                        else
                        begin
                            out_next.data_byte = q_op.data;
                            out_valid_next     = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        out_reg  <= out_next;
    end

endmodule

FILE: rtl/slip_frame_decoder_crc8_core.sv
// top level of the slip frame decoder with crc-8 check
// Usage:
//   Line bytes enter through push/full: a word is taken at a clock edge
//   with push high and full low. Decoded bytes and frame status words
//   leave through empty/pop: the oldest word sits on the result ports
//   while empty is low and is taken at an edge with pop high.
//   An escape byte gives no word; an END on an empty frame gives none.
//   In crc mode each data byte leaves one byte late and the trailing crc
//   byte never leaves; END then reports ok or crc error.
//   A pushed word is written into the queue and then moved into the result
//   register by the back end as soon as that register is free.
//   Throughput: one byte per cycle while pop keeps up, set by the
//   back end (unrolled crc-8 update and length compare) and result register.
//   When pop is held low the result register holds, the back end stops,
//   the four-entry queue fills and full rises; nothing is lost.
//   Reset clears the escape state, frame count, queue and result valid flag
//   and loads the register defaults (crc off, max length 65535, polynomial
//   0x07, initial value 0). The user must write registers over the apb port
//   only while the block is idle; the block itself does not enforce this.
module slip_frame_decoder_crc8_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        is_status,
    output logic [7:0]  data_byte,
    output logic [1:0]  status_code,
    output logic [15:0] frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slipd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic       fq_wr;
    op_t        fq_wr_op;
    logic       fq_rd;
    op_t        fq_rd_op;
    logic       fq_empty;
    result_t    res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CRC_ENABLE: cfg_next.crc_enable     = pwdata[0];
                REG_MAX_LENGTH: cfg_next.max_length     = pwdata[15:0];
                REG_CRC_POLY:   cfg_next.crc_polynomial = pwdata[7:0];
                REG_CRC_INIT:   cfg_next.crc_initial    = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_CRC_ENABLE: prdata = {31'd0, cfg_reg.crc_enable};
            REG_MAX_LENGTH: prdata = {16'd0, cfg_reg.max_length};
            REG_CRC_POLY:   prdata = {24'd0, cfg_reg.crc_polynomial};
            REG_CRC_INIT:   prdata = {24'd0, cfg_reg.crc_initial};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_enable     <= 1'b0;
            cfg_reg.max_length     <= 16'hFFFF;
            cfg_reg.crc_polynomial <= 8'h07;
            cfg_reg.crc_initial    <= 8'h00;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // escape decode and classification
    slipd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .q_full  (full),
        .q_wr    (fq_wr),
        .q_op    (fq_wr_op)
    );

    // decoupling queue
    slipd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fq_wr),
        .wr_op (fq_wr_op),
        .rd    (fq_rd),
        .rd_op (fq_rd_op),
        .full  (full),
        .empty (fq_empty)
    );

    // frame handling and result register
    slipd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (fq_empty),
        .q_op    (fq_rd_op),
        .q_rd    (fq_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (res)
    );

    assign is_status    = res.is_status;
    assign data_byte    = res.data_byte;
    assign status_code  = res.status_code;
    assign frame_length = res.frame_length;

endmodule
